/* sv/redundant_register_write_filter_top_assert.svh */
// Assertion macros for the redundant register write filter
`ifndef REDUNDANT_REGISTER_WRITE_FILTER_TOP_ASSERT_SVH
`define REDUNDANT_REGISTER_WRITE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RRWF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RRWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rrwf_pkg.sv */
// Types, constants and helpers shared by the write filter
package rrwf_pkg;

  localparam int unsigned REGS_PER_CHIP = 256;
  localparam int unsigned REG_W         = 8;
  localparam int unsigned DELAY_W       = 32;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PADDR_W       = 3;

  // Output queue: one slot for the result on display, one for the result being
  // decided, one for the item just taken.
  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Register index of delay_after_data (paddr[2])
  localparam logic CFG_IDX_DAD = 1'b0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e              opcode;
    logic                 chip_select;
    logic [REG_W-1:0]     reg_address;
    logic [REG_W-1:0]     write_value;
    logic [DELAY_W-1:0]   tick_delay;
  } item_t;

  typedef struct packed {
    logic [DELAY_W-1:0]   out_delay;
    logic                 out_chip;
    logic [REG_W-1:0]     out_reg;
    logic [REG_W-1:0]     out_value;
  } result_t;

  function automatic logic [DELAY_W-1:0] sat_add(input logic [DELAY_W-1:0] a,
                                                 input logic [DELAY_W-1:0] b);
    logic [DELAY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DELAY_W] ? {DELAY_W{1'b1}} : s[DELAY_W-1:0];
  endfunction

endpackage

/* sv/rrwf_stream_if.sv */
// Valid/ready channels for incoming write items and emitted writes
interface rrwf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic                       chip_select;
  logic [rrwf_pkg::REG_W-1:0]   reg_address;
  logic [rrwf_pkg::REG_W-1:0]   write_value;
  logic [rrwf_pkg::DELAY_W-1:0] tick_delay;

  modport source (output valid, opcode, chip_select, reg_address, write_value, tick_delay,
                  input ready);
  modport sink   (input valid, opcode, chip_select, reg_address, write_value, tick_delay,
                  output ready);
endinterface

interface rrwf_out_if;
  logic                       valid;
  logic                       ready;
  logic [rrwf_pkg::DELAY_W-1:0] out_delay;
  logic                       out_chip;
  logic [rrwf_pkg::REG_W-1:0]   out_reg;
  logic [rrwf_pkg::REG_W-1:0]   out_value;

  modport source (output valid, out_delay, out_chip, out_reg, out_value, input ready);
  modport sink   (input valid, out_delay, out_chip, out_reg, out_value, output ready);
endinterface

/* sv/rrwf_shadow_mem.sv */
// Shadow register memory with a zeroing sweep after reset
module rrwf_shadow_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [rrwf_pkg::REG_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [rrwf_pkg::REG_W-1:0] wr_data_i,
  output logic                       clr_done_o
);
  import rrwf_pkg::*;

  logic [REG_W-1:0] mem [DEPTH];
  logic [REG_W-1:0] rd_data_q;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             clr_done_q, clr_done_d;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_done_d = clr_done_q;
    if (!clr_done_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_done_d = 1'b1;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_done_q <= 1'b0;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_done_q <= clr_done_d;
    end
  end

  // Sweep has the port until done; no item is in flight during it
  always_ff @(posedge clk_i) begin
    if (!clr_done_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o  = rd_data_q;
  assign clr_done_o = clr_done_q;

endmodule

/* sv/rrwf_core.sv */
// Compare stage: shadow compare, delay accumulation and held-pair logic
module rrwf_core #(
  parameter int unsigned NUM_CHIPS = 2,
  parameter int unsigned AW        = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  rrwf_pkg::item_t            item_i,
  input  logic                       dad_i,
  input  logic [rrwf_pkg::REG_W-1:0] rd_data_i,
  output logic                       wr_en_o,
  output logic [AW-1:0]              wr_addr_o,
  output logic [rrwf_pkg::REG_W-1:0] wr_data_o,
  output logic                       res_valid_o,
  output rrwf_pkg::result_t          res_o,
  output logic                       busy_o
);
  import rrwf_pkg::*;

  logic               s1_v_q;
  item_t              s1_q;
  logic [AW-1:0]      slot;
  logic               chip_ok;
  logic [REG_W-1:0]   shadow;
  logic [DELAY_W-1:0] sum;

  logic               fwd_v_q;
  logic [AW-1:0]      fwd_addr_q;
  logic [REG_W-1:0]   fwd_data_q;

  logic [DELAY_W-1:0] pend_q, pend_d;
  logic               nh_q, nh_d;
  logic               held_chip_q, held_chip_d;
  logic [REG_W-1:0]   held_reg_q, held_reg_d;
  logic [REG_W-1:0]   held_val_q, held_val_d;
  logic               we;

  assign slot    = AW'({s1_q.chip_select, s1_q.reg_address});
  assign chip_ok = int'(s1_q.chip_select) < NUM_CHIPS;
  // The memory read issued at the accept edge misses a write at that same edge
  assign shadow  = (fwd_v_q && fwd_addr_q == slot) ? fwd_data_q : rd_data_i;
  assign sum     = sat_add(pend_q, s1_q.tick_delay);

  always_comb begin
    pend_d      = pend_q;
    nh_d        = nh_q;
    held_chip_d = held_chip_q;
    held_reg_d  = held_reg_q;
    held_val_d  = held_val_q;
    we          = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{out_delay: sum, out_chip: held_chip_q,
                    out_reg: held_reg_q, out_value: held_val_q};
    if (s1_v_q) begin
      if (s1_q.opcode == OP_FLUSH) begin
        if (dad_i) begin
          res_valid_o     = !nh_q;
          res_o.out_delay = pend_q;
          pend_d          = '0;
        end
        nh_d = 1'b1;
      end else if (!chip_ok || shadow == s1_q.write_value) begin
        pend_d = sum;
      end else begin
        we     = 1'b1;
        pend_d = '0;
        if (!dad_i) begin
          res_valid_o = 1'b1;
          res_o       = '{out_delay: sum, out_chip: s1_q.chip_select,
                          out_reg: s1_q.reg_address, out_value: s1_q.write_value};
        end else begin
          res_valid_o = !nh_q;
          nh_d        = 1'b0;
          held_chip_d = s1_q.chip_select;
          held_reg_d  = s1_q.reg_address;
          held_val_d  = s1_q.write_value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
      pend_q  <= '0;
      nh_q    <= 1'b1;
    end else begin
      s1_v_q  <= acc_i;
      fwd_v_q <= we;
      pend_q  <= pend_d;
      nh_q    <= nh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= item_i;
    end
    fwd_addr_q  <= slot;
    fwd_data_q  <= s1_q.write_value;
    held_chip_q <= held_chip_d;
    held_reg_q  <= held_reg_d;
    held_val_q  <= held_val_d;
  end

  assign wr_en_o   = we;
  assign wr_addr_o = slot;
  assign wr_data_o = s1_q.write_value;
  assign busy_o    = s1_v_q;

endmodule

/* sv/rrwf_out_fifo.sv */
// Small result queue between the compare stage and the output channel
module rrwf_out_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  rrwf_pkg::result_t                   push_data_i,
  input  logic                                pop_i,
  output logic                                valid_o,
  output rrwf_pkg::result_t                   data_o,
  output logic [rrwf_pkg::FIFO_CW-1:0]        count_o
);
  import rrwf_pkg::*;

  result_t            slots_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;

  function automatic logic [FIFO_PW-1:0] ptr_inc(input logic [FIFO_PW-1:0] p);
    return (p == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      cnt_q <= cnt_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = slots_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

/* sv/redundant_register_write_filter_top.sv */
// Path: an accepted item is registered in the compare stage, and its result, if any, is
//   pushed into the result queue that drives out_o. Throughput: one item per cycle
//   while the queue has room; the shadow memory read is issued at the accept edge and
//   compared in the cycle after, with a one-entry bypass for the write made at that same edge.
// Reset: asynchronous, active low. A zeroing sweep over all NUM_CHIPS*256 entries runs
//   through the shadow memory afterwards; in_i.ready stays low until it ends.
module redundant_register_write_filter_top #(
  parameter int unsigned NUM_CHIPS = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrwf_pkg::PADDR_W-1:0]  paddr,
  input  logic [rrwf_pkg::DATA_W-1:0]   pwdata,
  output logic [rrwf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  rrwf_in_if.sink                       in_i,
  rrwf_out_if.source                    out_o
);
  import rrwf_pkg::*;

  localparam int unsigned DEPTH = NUM_CHIPS * REGS_PER_CHIP;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic               dad_q;
  logic               clr_done;
  logic               in_acc;
  item_t              in_item;
  logic [AW-1:0]      rd_addr;
  logic [REG_W-1:0]   rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [REG_W-1:0]   wr_data;
  logic               res_push;
  result_t            res;
  logic               s1_busy;
  logic               pop;
  result_t            head;
  logic [FIFO_CW-1:0] fifo_cnt;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_DAD) ? {{(DATA_W-1){1'b0}}, dad_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dad_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_DAD) begin
      dad_q <= pwdata[0];
    end
  end

  // Room is reserved for the item in the compare stage and the one taken now
  assign in_i.ready = clr_done &&
                      (({1'b0, fifo_cnt} + (FIFO_CW+1)'(s1_busy)) <
                       (FIFO_CW+1)'(FIFO_DEPTH));
  assign in_acc  = in_i.valid && in_i.ready;
  assign in_item = '{opcode: opcode_e'(in_i.opcode), chip_select: in_i.chip_select,
                     reg_address: in_i.reg_address, write_value: in_i.write_value,
                     tick_delay: in_i.tick_delay};
  assign rd_addr = AW'({in_i.chip_select, in_i.reg_address});

  rrwf_shadow_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .clr_done_o (clr_done)
  );

  rrwf_core #(
    .NUM_CHIPS (NUM_CHIPS),
    .AW        (AW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .item_i      (in_item),
    .dad_i       (dad_q),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .res_valid_o (res_push),
    .res_o       (res),
    .busy_o      (s1_busy)
  );

  assign pop = out_o.valid && out_o.ready;

  rrwf_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .pop_i       (pop),
    .valid_o     (out_o.valid),
    .data_o      (head),
    .count_o     (fifo_cnt)
  );

  assign out_o.out_delay = head.out_delay;
  assign out_o.out_chip  = head.out_chip;
  assign out_o.out_reg   = head.out_reg;
  assign out_o.out_value = head.out_value;

`include "redundant_register_write_filter_top_assert.svh"

  `RRWF_ASSERT_IMPL(a_fifo_no_overflow, res_push && fifo_cnt == FIFO_CW'(FIFO_DEPTH), pop, "result queue overflow")
  `RRWF_ASSERT_IMPL(a_idle_during_sweep, !clr_done, !s1_busy && fifo_cnt == '0 && !wr_en, "activity during shadow clear")
  `RRWF_ASSERT_IMPL(a_result_has_item, res_push, $past(in_acc), "result without an accepted item")
  `RRWF_ASSERT_NEXT(a_empty_stays_quiet, fifo_cnt == '0 && !res_push, !out_o.valid, "output valid from empty queue")

endmodule
